// ===== rtl/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types, codes, constants and the CRC-8 byte step of the stepper
// driver UART datagram codec.
// ----------------------------------------------------------------------------
package sdc_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RX    = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SYNC = 2'd1,
        ST_BAD_REG  = 2'd2,
        ST_BAD_CRC  = 2'd3
    } status_t;

    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    localparam logic [7:0] SYNC_REQUEST = 8'hF5;
    localparam logic [7:0] SYNC_REPLY   = 8'h05;
    localparam logic [7:0] ADDR_REPLY   = 8'hFF;
    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [7:0] WRITE_FLAG   = 8'h80;

    localparam int QUEUE_DEPTH_DEFAULT = 2;
    localparam int RX_BYTES            = 10;
    localparam int RX_STORED           = RX_BYTES - 1;

    localparam logic [2:0] CRC_LEN_READ  = 3'd3;
    localparam logic [2:0] CRC_LEN_LONG  = 3'd7;
    localparam logic [3:0] TX_LEN_READ   = 4'd5;
    localparam logic [3:0] TX_LEN_WRITE  = 4'd10;
    localparam logic [3:0] CRC_GATE_READ  = 4'd3;
    localparam logic [3:0] CRC_GATE_WRITE = 4'd8;
    localparam logic [3:0] RX_LAST_COUNT = 4'(RX_BYTES - 1);

    typedef struct packed {
        logic            is_reply;
        logic            is_write;
        logic [6:0]      exp_reg;
        logic [7:0][7:0] data;
    } sdc_cmd_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] din);
        logic [7:0] c;
        logic [7:0] b;
        c = crc_in;
        b = din;
        for (int i = 0; i < 8; i++) begin
            if (c[7] ^ b[0]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
            b = {1'b0, b[7:1]};
        end
        return c;
    endfunction

endpackage

// ===== rtl/sdc_front.sv =====
// ----------------------------------------------------------------------------
// sdc_front
// Accepts input items, builds request datagram bytes, collects received
// framed bytes and deframes a complete reply into a command for the queue.
// ----------------------------------------------------------------------------
module sdc_front
    import sdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  node_address,
    input  logic [6:0]  register_index,
    input  logic [31:0] write_value,
    input  logic [7:0]  rx_byte,
    output logic        cmd_push,
    output sdc_cmd_t    cmd,
    input  logic        cmd_ready
);

    logic [6:0] exp_reg_reg;
    logic [6:0] exp_reg_next;
    logic [3:0] rx_count_reg;
    logic [3:0] rx_count_next;
    logic [7:0] frame_reg [RX_STORED];
    logic       frame_we;
    logic       accept;
    logic [8*RX_BYTES-1:0] stream;

    assign in_ready = cmd_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        stream[8*RX_BYTES-1 -: 8] = rx_byte;
        for (int m = 0; m < RX_STORED; m++) begin
            stream[8*m +: 8] = frame_reg[m];
        end
    end

    always_comb
    begin
        exp_reg_next  = exp_reg_reg;
        rx_count_next = rx_count_reg;
        frame_we      = 1'b0;
        cmd_push      = 1'b0;
        cmd           = '0;
        if (accept) begin
            unique case (op_t'(operation))
                OP_READ:
                begin
                    cmd_push      = 1'b1;
                    cmd.data[0]   = SYNC_REQUEST;
                    cmd.data[1]   = node_address;
                    cmd.data[2]   = {1'b0, register_index};
                    exp_reg_next  = register_index;
                    rx_count_next = '0;
                end
                OP_WRITE:
                begin
                    cmd_push      = 1'b1;
                    cmd.is_write  = 1'b1;
                    cmd.data[0]   = SYNC_REQUEST;
                    cmd.data[1]   = node_address;
                    cmd.data[2]   = {1'b0, register_index} | WRITE_FLAG;
                    cmd.data[3]   = write_value[31:24];
                    cmd.data[4]   = write_value[23:16];
                    cmd.data[5]   = write_value[15:8];
                    cmd.data[6]   = write_value[7:0];
                    rx_count_next = '0;
                end
                OP_RX:
                begin
                    if (rx_count_reg == RX_LAST_COUNT) begin
                        cmd_push     = 1'b1;
                        cmd.is_reply = 1'b1;
                        cmd.exp_reg  = exp_reg_reg;
                        for (int n = 0; n < 8; n++) begin
                            cmd.data[n] = stream[10*n+1 +: 8];
                        end
                        rx_count_next = '0;
                    end else begin
                        frame_we      = 1'b1;
                        rx_count_next = rx_count_reg + 4'd1;
                    end
                end
                OP_NONE:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            exp_reg_reg  <= '0;
            rx_count_reg <= '0;
        end else begin
            exp_reg_reg  <= exp_reg_next;
            rx_count_reg <= rx_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_we) begin
            frame_reg[rx_count_reg] <= rx_byte;
        end
    end

endmodule

// ===== rtl/sdc_queue.sv =====
// ----------------------------------------------------------------------------
// sdc_queue
// Short command queue that decouples the front from the back sequencer.
// ----------------------------------------------------------------------------
module sdc_queue
    import sdc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  sdc_cmd_t push_cmd,
    output logic     push_ready,
    input  logic     pop,
    output logic     pop_valid,
    output sdc_cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sdc_cmd_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/sdc_back.sv =====
// ----------------------------------------------------------------------------
// sdc_back
// Back sequencer: folds the CRC one byte per cycle; while the output is free,
// emits framed transmit bytes one per cycle or a checked reply, registered.
// ----------------------------------------------------------------------------
module sdc_back
    import sdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  sdc_cmd_t    cmd_in,
    output logic        cmd_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  tx_byte,
    output logic        last,
    output logic [31:0] reply_value,
    output logic [1:0]  reply_status
);

    sdc_cmd_t    cmd_reg;
    logic        busy_reg;
    logic        busy_next;
    logic [7:0]  crc_reg;
    logic [7:0]  crc_next;
    logic [2:0]  crc_cnt_reg;
    logic [2:0]  crc_cnt_next;
    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        kind_reg;
    logic [7:0]  tx_byte_reg;
    logic        last_reg;
    logic [31:0] reply_value_reg;
    logic [1:0]  reply_status_reg;

    logic [2:0]  crc_len;
    logic [3:0]  tx_len;
    logic [3:0]  crc_gate;
    logic        crc_done;
    logic        out_free;
    logic        emit_tx;
    logic        emit_reply;
    logic        finish;
    logic [79:0] stream;
    logic [6:0]  bit_pos;
    logic [7:0]  tx_sel;
    status_t     status;

    assign crc_len  = (cmd_reg.is_write || cmd_reg.is_reply) ? CRC_LEN_LONG : CRC_LEN_READ;
    assign tx_len   = cmd_reg.is_write ? TX_LEN_WRITE : TX_LEN_READ;
    assign crc_gate = cmd_reg.is_write ? CRC_GATE_WRITE : CRC_GATE_READ;
    assign crc_done = (crc_cnt_reg == crc_len);
    assign out_free = !out_valid_reg || out_ready;

    assign emit_tx    = busy_reg && !cmd_reg.is_reply && out_free
                        && ((pos_reg < crc_gate) || crc_done);
    assign emit_reply = busy_reg && cmd_reg.is_reply && out_free && crc_done;
    assign finish     = emit_reply || (emit_tx && (pos_reg == tx_len - 4'd1));
    assign cmd_pop    = cmd_valid && (!busy_reg || finish);

    always_comb
    begin
        for (int n = 0; n < 8; n++) begin
            if (3'(n) == crc_len) begin
                stream[10*n +: 10] = {1'b1, crc_reg, 1'b0};
            end else begin
                stream[10*n +: 10] = {1'b1, cmd_reg.data[n], 1'b0};
            end
        end
    end

    assign bit_pos = {pos_reg, 3'b000};
    assign tx_sel  = stream[bit_pos +: 8];

    always_comb
    begin
        if ((cmd_reg.data[0] != SYNC_REPLY) || (cmd_reg.data[1] != ADDR_REPLY)) begin
            status = ST_BAD_SYNC;
        end else if (cmd_reg.data[2] != {1'b0, cmd_reg.exp_reg}) begin
            status = ST_BAD_REG;
        end else if (crc_reg != cmd_reg.data[7]) begin
            status = ST_BAD_CRC;
        end else begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        busy_next    = busy_reg;
        crc_next     = crc_reg;
        crc_cnt_next = crc_cnt_reg;
        pos_next     = pos_reg;
        if (busy_reg && !crc_done) begin
            crc_next     = crc8_byte(crc_reg, cmd_reg.data[crc_cnt_reg]);
            crc_cnt_next = crc_cnt_reg + 3'd1;
        end
        if (emit_tx) begin
            pos_next = pos_reg + 4'd1;
        end
        if (finish) begin
            busy_next = 1'b0;
        end
        if (cmd_pop) begin
            busy_next    = 1'b1;
            crc_next     = '0;
            crc_cnt_next = '0;
            pos_next     = '0;
        end
        out_valid_next = (emit_tx || emit_reply) ? 1'b1
                       : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg     <= crc_next;
        crc_cnt_reg <= crc_cnt_next;
        pos_reg     <= pos_next;
        if (cmd_pop) begin
            cmd_reg <= cmd_in;
        end
        if (emit_tx) begin
            kind_reg         <= KIND_TX;
            tx_byte_reg      <= tx_sel;
            last_reg         <= (pos_reg == tx_len - 4'd1);
            reply_value_reg  <= '0;
            reply_status_reg <= ST_OK;
        end else if (emit_reply) begin
            kind_reg         <= KIND_REPLY;
            tx_byte_reg      <= '0;
            last_reg         <= 1'b0;
            reply_value_reg  <= {cmd_reg.data[3], cmd_reg.data[4],
                                 cmd_reg.data[5], cmd_reg.data[6]};
            reply_status_reg <= status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign tx_byte      = tx_byte_reg;
    assign last         = last_reg;
    assign reply_value  = reply_value_reg;
    assign reply_status = reply_status_reg;

endmodule

// ===== rtl/stepper_driver_uart_datagram_codec_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_driver_uart_datagram_codec_unit
// Builds and checks single-wire UART datagrams for a stepper driver.
// ----------------------------------------------------------------------------
// The front accepts one request every cycle while the command queue has room.
// A read request then comes out as five framed bytes and a write request as
// ten framed bytes, one byte per cycle while the output is not stalled, from the
// back sequencer, which folds the CRC one byte per cycle alongside the output.
// Received bytes are taken one per cycle while the queue has room; the tenth
// queues a reply check, which the sequencer emits once its CRC fold is done.
module stepper_driver_uart_datagram_codec_unit
    import sdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  node_address,
    input  logic [6:0]  register_index,
    input  logic [31:0] write_value,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  tx_byte,
    output logic        last,
    output logic [31:0] reply_value,
    output logic [1:0]  reply_status
);

    logic     q_push;
    logic     q_ready;
    sdc_cmd_t q_in;
    logic     q_pop;
    logic     q_valid;
    sdc_cmd_t q_out;

    sdc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .node_address   (node_address),
        .register_index (register_index),
        .write_value    (write_value),
        .rx_byte        (rx_byte),
        .cmd_push       (q_push),
        .cmd            (q_in),
        .cmd_ready      (q_ready)
    );

    sdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_cmd    (q_out)
    );

    sdc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_valid),
        .cmd_in       (q_out),
        .cmd_pop      (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .tx_byte      (tx_byte),
        .last         (last),
        .reply_value  (reply_value),
        .reply_status (reply_status)
    );

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_ready)
        else $error("Command pushed into a full queue.");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("Command popped from an empty queue.");

    a_reply_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_REPLY)) |-> (!last && (tx_byte == 8'd0)))
        else $error("Reply carries transmit byte fields.");

endmodule

// ===== verif/tb_stepper_driver_uart_datagram_codec_unit.sv =====
// ----------------------------------------------------------------------------
// Testbench for stepper_driver_uart_datagram_codec_unit
// Sends read and write requests and received reply bytes through the request
// handshake, and predicts every framed transmit byte and every decoded reply.
// Each result is checked against the prediction, with random idling on both
// sides except in the back-to-back test.
// ----------------------------------------------------------------------------
module tb_stepper_driver_uart_datagram_codec_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import sdc_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 50;
    localparam int REPORT_LIMIT = 40;

    typedef logic [7:0][7:0] octets_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [31:0] reply_value;
        status_t     reply_status;
    } codec_result_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_SYNC,
        FLAW_ADDR,
        FLAW_REG,
        FLAW_REG_HIGH,
        FLAW_CRC
    } reply_flaw_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    op_t         operation = OP_NONE;
    logic [7:0]  node_address = '0;
    logic [6:0]  register_index = '0;
    logic [31:0] write_value = '0;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [31:0] reply_value;
    logic [1:0]  reply_status;

    logic [6:0]       model_expected_reg = '0;
    int               model_rx_count = 0;
    logic [9:0][7:0]  model_rx_bytes = '0;
    codec_result_t    outputs_due[$];

    logic idle_enabled = 1'b1;
    int   stall_left = 0;
    int   cycle_count = 0;
    int   error_count = 0;
    int   items_sent = 0;
    int   reads_sent = 0;
    int   writes_sent = 0;
    int   rx_sent = 0;
    int   tx_checked = 0;
    int   replies_checked = 0;
    int   status_seen [4] = '{0, 0, 0, 0};
    codec_result_t due;

    stepper_driver_uart_datagram_codec_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .node_address   (node_address),
        .register_index (register_index),
        .write_value    (write_value),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .tx_byte        (tx_byte),
        .last           (last),
        .reply_value    (reply_value),
        .reply_status   (reply_status)
    );

    always #5ns clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL stepper_driver_uart_datagram_codec_unit");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (idle_enabled && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 13);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] fold_crc(octets_t raw, int count);
        logic [7:0] crc;
        logic       feedback;
        crc = 8'h00;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 8; i++)
            begin
                feedback = crc[7] ^ raw[n][i];
                crc = {crc[6:0], 1'b0};
                if (feedback)
                begin
                    crc = crc ^ CRC_POLY;
                end
            end
        end
        return crc;
    endfunction

    function automatic logic [79:0] frame_octets(octets_t raw, int count);
        logic [79:0] stream;
        stream = '0;
        for (int n = 0; n < count; n++)
        begin
            stream[n * 10 +: 10] = {1'b1, raw[n], 1'b0};
        end
        return stream;
    endfunction

    task automatic queue_datagram_bytes(op_t op, logic [7:0] node, logic [6:0] reg_idx,
                                        logic [31:0] value);
        octets_t       raw;
        logic [79:0]   stream;
        int            raw_count;
        int            out_count;
        codec_result_t r;
        raw = '0;
        raw[0] = SYNC_REQUEST;
        raw[1] = node;
        if (op == OP_READ)
        begin
            raw[2] = {1'b0, reg_idx};
            raw[3] = fold_crc(raw, 3);
            raw_count = 4;
            model_expected_reg = reg_idx;
        end
        else
        begin
            raw[2] = WRITE_FLAG | {1'b0, reg_idx};
            raw[3] = value[31:24];
            raw[4] = value[23:16];
            raw[5] = value[15:8];
            raw[6] = value[7:0];
            raw[7] = fold_crc(raw, 7);
            raw_count = 8;
        end
        model_rx_count = 0;
        stream = frame_octets(raw, raw_count);
        out_count = raw_count * 10 / 8;
        for (int k = 0; k < out_count; k++)
        begin
            r.kind = KIND_TX;
            r.tx_byte = stream[k * 8 +: 8];
            r.last = (k == out_count - 1);
            r.reply_value = '0;
            r.reply_status = ST_OK;
            outputs_due.insert(outputs_due.size(), r);
        end
    endtask

    task automatic absorb_rx_byte(logic [7:0] b);
        logic [79:0]   stream;
        octets_t       d;
        codec_result_t r;
        model_rx_bytes[model_rx_count] = b;
        model_rx_count++;
        if (model_rx_count == RX_BYTES)
        begin
            model_rx_count = 0;
            stream = model_rx_bytes;
            for (int n = 0; n < 8; n++)
            begin
                d[n] = stream[n * 10 + 1 +: 8];
            end
            r.kind = KIND_REPLY;
            r.tx_byte = '0;
            r.last = 1'b0;
            r.reply_value = {d[3], d[4], d[5], d[6]};
            if (d[0] != SYNC_REPLY || d[1] != ADDR_REPLY)
            begin
                r.reply_status = ST_BAD_SYNC;
            end
            else if (d[2] != {1'b0, model_expected_reg})
            begin
                r.reply_status = ST_BAD_REG;
            end
            else if (fold_crc(d, 7) != d[7])
            begin
                r.reply_status = ST_BAD_CRC;
            end
            else
            begin
                r.reply_status = ST_OK;
            end
            outputs_due.insert(outputs_due.size(), r);
        end
    endtask

    task automatic send_item(op_t op, logic [7:0] node, logic [6:0] reg_idx,
                             logic [31:0] value, logic [7:0] rx);
        if (idle_enabled && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        node_address <= node;
        register_index <= reg_idx;
        write_value <= value;
        rx_byte <= rx;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        case (op)
            OP_READ:
            begin
                queue_datagram_bytes(op, node, reg_idx, value);
                reads_sent++;
            end
            OP_WRITE:
            begin
                queue_datagram_bytes(op, node, reg_idx, value);
                writes_sent++;
            end
            OP_RX:
            begin
                absorb_rx_byte(rx);
                rx_sent++;
            end
            default:
            begin
            end
        endcase
        if (op != OP_NONE)
        begin
            items_sent++;
        end
    endtask

    task automatic send_read(logic [7:0] node, logic [6:0] reg_idx);
        send_item(OP_READ, node, reg_idx, $urandom, 8'($urandom));
    endtask

    task automatic send_write(logic [7:0] node, logic [6:0] reg_idx, logic [31:0] value);
        send_item(OP_WRITE, node, reg_idx, value, 8'($urandom));
    endtask

    // Sends the first count framed bytes of a reply aimed at the last read register.
    task automatic send_reply(reply_flaw_t flaw, int count);
        octets_t     d;
        logic [79:0] stream;
        d[0] = SYNC_REPLY;
        d[1] = ADDR_REPLY;
        d[2] = {1'b0, model_expected_reg};
        d[6:3] = $urandom;
        d[7] = fold_crc(d, 7);
        case (flaw)
            FLAW_SYNC:     d[0] = d[0] ^ 8'($urandom_range(1, 255));
            FLAW_ADDR:     d[1] = d[1] ^ 8'($urandom_range(1, 255));
            FLAW_REG:      d[2] = d[2] ^ {1'b0, 7'($urandom_range(1, 127))};
            FLAW_REG_HIGH: d[2] = d[2] | WRITE_FLAG;
            FLAW_CRC:      d[7] = d[7] ^ 8'($urandom_range(1, 255));
            default:       d[7] = d[7];
        endcase
        stream = frame_octets(d, 8);
        if ($urandom_range(0, 3) == 0)
        begin
            for (int n = 0; n < 8; n++)
            begin
                stream[n * 10] = 1'($urandom);
                stream[n * 10 + 9] = 1'($urandom);
            end
        end
        for (int k = 0; k < count; k++)
        begin
            send_item(OP_RX, 8'($urandom), 7'($urandom), $urandom, stream[k * 8 +: 8]);
        end
    endtask

    task automatic run_mixed_traffic(int count);
        int          target;
        int          pick;
        reply_flaw_t flaw;
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: flaw = FLAW_NONE;
                4:          flaw = FLAW_SYNC;
                5:          flaw = FLAW_ADDR;
                6:          flaw = FLAW_REG;
                7:          flaw = FLAW_REG_HIGH;
                default:    flaw = FLAW_CRC;
            endcase
            if (pick < 22)
            begin
                send_read(8'($urandom), 7'($urandom));
            end
            else if (pick < 36)
            begin
                send_write(8'($urandom), 7'($urandom), $urandom);
            end
            else if (pick < 80)
            begin
                send_reply(flaw, RX_BYTES);
            end
            else if (pick < 90)
            begin
                send_reply(flaw, $urandom_range(1, RX_BYTES - 1));
            end
            else if (pick < 96)
            begin
                repeat ($urandom_range(1, 12))
                    send_item(OP_RX, 8'($urandom), 7'($urandom), $urandom, 8'($urandom));
            end
            else
            begin
                send_item(OP_NONE, 8'($urandom), 7'($urandom), $urandom, 8'($urandom));
            end
        end
    endtask

    task automatic test_request_extremes();
        send_read(8'h00, 7'h00);
        send_read(8'hFF, 7'h7F);
        send_write(8'h00, 7'h7F, 32'hFFFF_FFFF);
        send_write(8'hFF, 7'h00, 32'h0000_0000);
        send_item(OP_NONE, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
    endtask

    task automatic test_good_reply();
        send_read(8'h01, 7'h6C);
        send_reply(FLAW_NONE, RX_BYTES);
    endtask

    task automatic test_restart_mid_reply();
        send_reply(FLAW_NONE, 3);
        send_write(8'h5A, 7'h22, 32'h8000_0001);
    endtask

    task automatic test_random_traffic();
        idle_enabled = 1'b1;
        run_mixed_traffic(390);
    endtask

    task automatic test_back_to_back();
        idle_enabled = 1'b0;
        run_mixed_traffic(60);
    endtask

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, expected, actual);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (outputs_due.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual kind %0b tx %0h value %0h",
                         $time, kind, tx_byte, reply_value);
            end
            else
            begin
                due = outputs_due.pop_front();
                check_field("kind", 32'(due.kind), 32'(kind));
                check_field("tx_byte", 32'(due.tx_byte), 32'(tx_byte));
                check_field("last", 32'(due.last), 32'(last));
                check_field("reply_value", due.reply_value, reply_value);
                check_field("reply_status", 32'(due.reply_status), 32'(reply_status));
                if (due.kind == KIND_REPLY)
                begin
                    replies_checked++;
                    status_seen[due.reply_status]++;
                end
                else
                begin
                    tx_checked++;
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_request_extremes();
        test_good_reply();
        test_restart_mid_reply();
        test_random_traffic();
        test_back_to_back();
        in_valid <= 1'b0;
        while (outputs_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d reads, %0d writes and %0d received bytes; checked %0d transmit bytes.",
                 reads_sent, writes_sent, rx_sent, tx_checked);
        $display("Checked %0d replies: %0d ok, %0d bad sync, %0d bad register, %0d bad crc.",
                 replies_checked, status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3]);
        if (error_count == 0)
        begin
            $display("PASS stepper_driver_uart_datagram_codec_unit");
        end
        else
        begin
            $display("FAIL stepper_driver_uart_datagram_codec_unit");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sdc_pkg.sv
rtl/sdc_front.sv
rtl/sdc_queue.sv
rtl/sdc_back.sv
rtl/stepper_driver_uart_datagram_codec_unit.sv
verif/tb_stepper_driver_uart_datagram_codec_unit.sv
